// ===== src/sphere_overlap_all_pairs_macros.svh =====
// Assertion macros shared by the checker of the sphere overlap block.
// No dependencies.
`ifndef SPHERE_OVERLAP_ALL_PAIRS_MACROS_SVH
`define SPHERE_OVERLAP_ALL_PAIRS_MACROS_SVH
`define SOAP_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define SOAP_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== src/soap_pkg.sv =====
// Package for the sphere overlap block: widths, types and the state code.
// No dependencies.
package soap_pkg;
  localparam int MAX_ENTRIES = 64;
  localparam int COORD_BITS = 24;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W = 16;
  localparam int RAD_W = 23;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W = 2 * DIFF_W;
  localparam int D2_W = SQ_W + 2;
  localparam int RS_W = RAD_W + 1;
  localparam int RS2_W = 2 * RS_W;
  localparam int POS_W = 3 * COORD_BITS;
  localparam int ENT_W = ID_W + POS_W + RAD_W;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // One stored collider.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [RAD_W-1:0] rad;
  } coll_t;

  // Pair issue control, sequencer to pair unit.
  typedef struct packed {
    logic valid;
    logic self;
    logic first;
    logic last_j;
  } pair_ctl_t;
endpackage

// ===== src/soap_store.sv =====
// Collider memory: one write port, two registered read ports.
// Depends on soap_pkg.
module soap_store
  import soap_pkg::*;
(
  input  logic clk,
  input  logic we,
  input  logic [IDX_W-1:0] waddr,
  input  coll_t wdata,
  input  logic [IDX_W-1:0] raddr_a,
  input  logic [IDX_W-1:0] raddr_b,
  output coll_t rdata_a,
  output coll_t rdata_b
);
  coll_t mem [MAX_ENTRIES];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ===== src/soap_pair.sv =====
// Pipelined pair test: differences, squares, sums, compare, hit accumulation.
// Depends on soap_pkg.
module soap_pair
  import soap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  pair_ctl_t ctl,
  input  coll_t ca,
  input  coll_t cb,
  output logic done,
  output logic [ID_W-1:0] res_id,
  output logic res_hit,
  output logic [ID_W-1:0] res_into
);
  pair_ctl_t c1, c2, c3;
  logic [DIFF_W-1:0] dx, dy, dz;
  logic [RS_W-1:0] rs;
  logic [ID_W-1:0] ida1, idb1, ida2, idb2, ida3, idb3;
  logic [SQ_W-1:0] sx, sy, sz;
  logic [RS2_W-1:0] rs2;
  logic [D2_W-1:0] d2;
  logic [RS2_W-1:0] rs2_3;
  logic [DIFF_W-1:0] ax, ay, az, bx, by, bz;

  always_comb begin
    ax = {ca.x[COORD_BITS-1], ca.x};
    ay = {ca.y[COORD_BITS-1], ca.y};
    az = {ca.z[COORD_BITS-1], ca.z};
    bx = {cb.x[COORD_BITS-1], cb.x};
    by = {cb.y[COORD_BITS-1], cb.y};
    bz = {cb.z[COORD_BITS-1], cb.z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      done <= 1'b0;
    end else begin
      c1 <= ctl;
      c2 <= c1;
      c3 <= c2;
      done <= c3.valid && c3.last_j;
    end
    // Stage 1: absolute differences and radius sum.
    dx <= ($signed(ax) >= $signed(bx)) ? ax - bx : bx - ax;
    dy <= ($signed(ay) >= $signed(by)) ? ay - by : by - ay;
    dz <= ($signed(az) >= $signed(bz)) ? az - bz : bz - az;
    rs <= {1'b0, ca.rad} + {1'b0, cb.rad};
    ida1 <= ca.id;
    idb1 <= cb.id;
    // Stage 2: squares.
    sx <= dx * dx;
    sy <= dy * dy;
    sz <= dz * dz;
    rs2 <= rs * rs;
    ida2 <= ida1;
    idb2 <= idb1;
    // Stage 3: sum of squares; the squared radius sum moves along with it.
    d2 <= {2'b00, sx} + {2'b00, sy} + {2'b00, sz};
    rs2_3 <= rs2;
    ida3 <= ida2;
    idb3 <= idb2;
    // Stage 4: compare and accumulate per row.
    if (c3.valid) begin
      if (c3.first) begin
        res_id <= ida3;
        res_hit <= 1'b0;
        res_into <= '0;
      end
      if (!c3.self && ({{(D2_W-RS2_W){1'b0}}, rs2_3} > d2)) begin
        res_hit <= 1'b1;
        res_into <= idb3;
      end
    end
  end
endmodule

// ===== src/sphere_overlap_all_pairs.sv =====
// Top level of the sphere overlap block: load, pair sequencing and results.
// Depends on soap_pkg, soap_store and soap_pair.
//
//  channel | signals                                         | role
//  in      | valid ready entity_id pos_x/y/z radius last     | one collider per item
//  out     | out_valid out_ready collider_entity hit ...     | one result per collider
//
// Items are accepted back to back while loading. On the last item the block
// tests all N*N ordered pairs, one pair per cycle through the pair pipeline;
// each collider's row of N pairs is issued and then drained, bounded by the
// single pair unit and the two memory read ports. Each result waits in an
// output register until taken; the next row starts only after that. Reset
// zeroes the entry count, which empties the store; no clearing pass is needed.
module sphere_overlap_all_pairs
  import soap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [ID_W-1:0] entity_id,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [RAD_W-1:0] radius,
  input  logic last,
  output logic out_valid,
  input  logic out_ready,
  output logic [ID_W-1:0] collider_entity,
  output logic hit,
  output logic [ID_W-1:0] into_entity,
  output logic last_result
);
  state_t state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] row, col;
  logic accept;
  coll_t wdata, rd_a, rd_b;
  pair_ctl_t ctl, ctl_q;
  logic pdone;
  logic [ID_W-1:0] p_id, p_into;
  logic p_hit;
  logic room;

  assign ready = (state == ST_LOAD);
  assign accept = valid && ready;
  assign room = (count < CNT_W'(MAX_ENTRIES));

  always_comb begin
    wdata.id = entity_id;
    wdata.x = pos_x[COORD_BITS-1:0];
    wdata.y = pos_y[COORD_BITS-1:0];
    wdata.z = pos_z[COORD_BITS-1:0];
    wdata.rad = radius;
  end

  // Reads issued during RUN; the registered data appears in the next cycle, with ctl_q.
  always_comb begin
    ctl.valid = (state == ST_RUN);
    ctl.self = (row == col);
    ctl.first = (col == '0);
    ctl.last_j = ({1'b0, col} == count - CNT_W'(1));
  end

  soap_store u_store (
    .clk(clk), .we(accept && room), .waddr(count[IDX_W-1:0]), .wdata(wdata),
    .raddr_a(row), .raddr_b(col), .rdata_a(rd_a), .rdata_b(rd_b)
  );

  soap_pair u_pair (
    .clk(clk), .rst(rst), .ctl(ctl_q), .ca(rd_a), .cb(rd_b),
    .done(pdone), .res_id(p_id), .res_hit(p_hit), .res_into(p_into)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      row <= '0;
      col <= '0;
      ctl_q <= '0;
      out_valid <= 1'b0;
    end else begin
      ctl_q <= ctl;
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end
            if (last) begin
              // When there is room, the store write of this item lands before the first read.
              if (room) begin
                state <= ST_RUN;
              end else begin
                state <= ST_RUN;
              end
              row <= '0;
              col <= '0;
            end
          end
        end
        ST_RUN: begin
          if (ctl.last_j) begin
            state <= ST_DRAIN;
            col <= '0;
          end else begin
            col <= col + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (pdone) begin
            out_valid <= 1'b1;
            collider_entity <= p_id;
            hit <= p_hit;
            into_entity <= p_into;
            last_result <= ({1'b0, row} == count - CNT_W'(1));
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_result) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              row <= row + IDX_W'(1);
              state <= ST_RUN;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end
endmodule

// ===== src/soap_check.sv =====
// Port-level checker for the sphere overlap block, bound to the top level.
// Depends on sphere_overlap_all_pairs_macros.svh.
`include "sphere_overlap_all_pairs_macros.svh"
module soap_check (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input logic out_valid,
  input logic out_ready,
  input logic last,
  input logic last_result
);
  `SOAP_ASSERT_IMPL(a_no_in_while_out, out_valid, !ready)
  `SOAP_ASSERT_NEXT(a_last_stops_in, valid && ready && last, !ready)
  `SOAP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(last_result))
endmodule

bind sphere_overlap_all_pairs soap_check u_check (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .out_valid(out_valid),
  .out_ready(out_ready), .last(last), .last_result(last_result)
);
